>>> rtl/core/bdq_pkg.sv
// Shared types and codes for the bounded deque.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 4;
    localparam int KCNT_W = 7;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
    localparam logic [OP_W-1:0] OP_EMIT_ALL   = 4'd6;
    localparam logic [OP_W-1:0] OP_EMIT_FIRST = 4'd7;
    localparam logic [OP_W-1:0] OP_EMIT_LAST  = 4'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } t_state;

endpackage

>>> rtl/core/bdq_mem.sv
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bdq_mem #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(CAPACITY)-1:0]         i_waddr,
    input  logic signed [bdq_pkg::WORD_W-1:0]   i_wdata,
    input  logic [$clog2(CAPACITY)-1:0]         i_raddr,
    output logic signed [bdq_pkg::WORD_W-1:0]   o_rdata
);

    logic signed [bdq_pkg::WORD_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/core/bdq_slot.sv
// Circular address unit: (base + offset) mod CAPACITY.
`timescale 1ns / 1ps

module bdq_slot #(
    parameter int CAPACITY = 64
) (
    input  logic [$clog2(CAPACITY)-1:0]   i_base,
    input  logic [$clog2(CAPACITY+1)-1:0] i_offset,
    output logic [$clog2(CAPACITY)-1:0]   o_slot
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W:0] sum;
    logic [CNT_W:0] wrapped;

    always_comb begin
        sum = (CNT_W + 1)'(i_base) + (CNT_W + 1)'(i_offset);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            wrapped = sum - (CNT_W + 1)'(CAPACITY);
        end else begin
            wrapped = sum;
        end
        o_slot = wrapped[IDX_W-1:0];
    end

endmodule

>>> rtl/core/bdq_ctrl.sv
// Command sequencer: pointers, fill count, scan/shift/emit walks.
`timescale 1ns / 1ps

module bdq_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bdq_pkg::OP_W-1:0]            i_operation,
    input  logic signed [bdq_pkg::WORD_W-1:0]   i_value,
    input  logic [bdq_pkg::KCNT_W-1:0]          i_count,
    input  logic signed [bdq_pkg::WORD_W-1:0]   i_rd_data,
    output logic                                o_we,
    output logic [$clog2(CAPACITY)-1:0]         o_waddr,
    output logic signed [bdq_pkg::WORD_W-1:0]   o_wdata,
    output logic [$clog2(CAPACITY)-1:0]         o_raddr,
    output logic                                o_strobe,
    output logic                                o_is_last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    bdq_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_left, n_left;
    logic [IDX_W-1:0] r_prev_addr, n_prev_addr;
    logic [IDX_W-1:0] r_wr_addr, n_wr_addr;
    logic             r_cmp_valid, n_cmp_valid;
    logic signed [bdq_pkg::WORD_W-1:0] r_val, n_val;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;

    logic [CNT_W-1:0] offset;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] emit_n;

    bdq_slot #(.CAPACITY(CAPACITY)) u_slot (
        .i_base  (r_front),
        .i_offset(offset),
        .o_slot  (slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_front     <= '0;
            r_fill      <= '0;
            r_cmp_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_fill      <= n_fill;
            r_cmp_valid <= n_cmp_valid;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_left      <= n_left;
        r_prev_addr <= n_prev_addr;
        r_wr_addr   <= n_wr_addr;
        r_val       <= n_val;
    end

    always_comb begin
        if (i_operation != bdq_pkg::OP_EMIT_ALL &&
            i_count < bdq_pkg::KCNT_W'(r_fill)) begin
            emit_n = i_count[CNT_W-1:0];
        end else begin
            emit_n = r_fill;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_left      = r_left;
        n_prev_addr = r_prev_addr;
        n_wr_addr   = r_wr_addr;
        n_cmp_valid = r_cmp_valid;
        n_val       = r_val;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        offset      = r_idx;
        o_we        = 1'b0;
        o_waddr     = slot;
        o_wdata     = i_value;

        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                unique case (i_operation)
                    bdq_pkg::OP_PUSH_FRONT: offset = CNT_W'(CAPACITY - 1);
                    bdq_pkg::OP_PUSH_BACK:  offset = r_fill;
                    bdq_pkg::OP_POP_FRONT:  offset = CNT_W'(1);
                    default:                offset = '0;
                endcase
                if (start) begin
                    unique case (i_operation)
                        bdq_pkg::OP_PUSH_FRONT: begin
                            if (r_fill < CNT_W'(CAPACITY)) begin
                                o_we    = 1'b1;
                                n_front = slot;
                                n_fill  = r_fill + 1'b1;
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK: begin
                            if (r_fill < CNT_W'(CAPACITY)) begin
                                o_we   = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        bdq_pkg::OP_POP_FRONT: begin
                            if (r_fill != '0) begin
                                n_front = slot;
                                n_fill  = r_fill - 1'b1;
                            end
                        end
                        bdq_pkg::OP_POP_BACK: begin
                            if (r_fill != '0) begin
                                n_fill = r_fill - 1'b1;
                            end
                        end
                        bdq_pkg::OP_CLEAR: begin
                            n_fill  = '0;
                            n_front = '0;
                        end
                        bdq_pkg::OP_REMOVE: begin
                            if (r_fill != '0) begin
                                n_state     = bdq_pkg::S_SCAN;
                                n_idx       = '0;
                                n_cmp_valid = 1'b0;
                                n_val       = i_value;
                            end
                        end
                        bdq_pkg::OP_EMIT_ALL, bdq_pkg::OP_EMIT_FIRST,
                        bdq_pkg::OP_EMIT_LAST: begin
                            if (emit_n != '0) begin
                                n_state = bdq_pkg::S_EMIT;
                                n_left  = emit_n;
                                n_idx   = (i_operation == bdq_pkg::OP_EMIT_LAST) ?
                                          r_fill - emit_n : '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bdq_pkg::S_SCAN: begin
                if (r_cmp_valid && i_rd_data == r_val) begin
                    if (r_idx >= r_fill) begin
                        n_fill  = r_fill - 1'b1;
                        n_state = bdq_pkg::S_IDLE;
                    end else begin
                        n_state     = bdq_pkg::S_SHIFT;
                        n_wr_addr   = r_prev_addr;
                        n_prev_addr = slot;
                        n_idx       = r_idx + 1'b1;
                    end
                end else if (r_idx == r_fill) begin
                    n_state = bdq_pkg::S_IDLE;
                end else begin
                    n_prev_addr = slot;
                    n_idx       = r_idx + 1'b1;
                    n_cmp_valid = 1'b1;
                end
            end
            bdq_pkg::S_SHIFT: begin
                o_we      = 1'b1;
                o_waddr   = r_wr_addr;
                o_wdata   = i_rd_data;
                n_wr_addr = r_prev_addr;
                if (r_idx < r_fill) begin
                    n_prev_addr = slot;
                    n_idx       = r_idx + 1'b1;
                end else begin
                    n_fill  = r_fill - 1'b1;
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            bdq_pkg::S_EMIT: begin
                n_pend      = 1'b1;
                n_pend_last = (r_left == CNT_W'(1));
                n_idx       = r_idx + 1'b1;
                n_left      = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            default: n_state = bdq_pkg::S_IDLE;
        endcase
    end

    assign o_raddr   = slot;
    assign busy      = (r_state != bdq_pkg::S_IDLE);
    assign o_strobe  = r_pend;
    assign o_is_last = r_pend & r_pend_last;

endmodule

>>> rtl/core/bounded_deque_with_value_delete.sv
// Top level of the bounded double-ended queue with delete by value.
//
// Command channel: a word (i_operation, i_value, i_count) is taken at a rising
// edge with start high and busy low. Push, pop, clear and unused codes finish
// in the accepting cycle; busy stays low.
// Remove by value walks the stored elements one per cycle through the shared
// circular address unit and the single read port of the store, first for the
// search and then for the gap closing.
// Emit commands read one element per cycle.
// Each result word appears on o_element / o_is_last for one cycle with
// o_strobe high, the first after the emit state reads it from the store,
// then one per cycle in front-to-back order; o_is_last marks the final word.
// The receiver cannot stall; every strobe is a delivered word.
// Reset (synchronous, active low) empties the queue and returns to idle;
// the store contents are not cleared.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bdq_pkg::OP_W-1:0]            i_operation,
    input  logic signed [bdq_pkg::WORD_W-1:0]   i_value,
    input  logic [bdq_pkg::KCNT_W-1:0]          i_count,
    output logic                                o_strobe,
    output logic signed [bdq_pkg::WORD_W-1:0]   o_element,
    output logic                                o_is_last
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                              we;
    logic [IDX_W-1:0]                  waddr;
    logic signed [bdq_pkg::WORD_W-1:0] wdata;
    logic [IDX_W-1:0]                  raddr;
    logic signed [bdq_pkg::WORD_W-1:0] rdata;

    bdq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operation(i_operation),
        .i_value    (i_value),
        .i_count    (i_count),
        .i_rd_data  (rdata),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .o_strobe   (o_strobe),
        .o_is_last  (o_is_last)
    );

    bdq_mem #(.CAPACITY(CAPACITY)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_element = rdata;

endmodule

>>> rtl/core/bdq_chk.sv
// Port-level checks for the bounded deque, bound to the top level.
`timescale 1ns / 1ps

module bdq_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [bdq_pkg::OP_W-1:0]            i_operation,
    input logic                                o_strobe,
    input logic                                o_is_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("not idle after reset");

    a_short_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy &&
        (i_operation == bdq_pkg::OP_PUSH_FRONT || i_operation == bdq_pkg::OP_PUSH_BACK ||
         i_operation == bdq_pkg::OP_POP_FRONT || i_operation == bdq_pkg::OP_POP_BACK ||
         i_operation == bdq_pkg::OP_CLEAR)
        |=> !busy && !o_strobe)
        else $error("single-cycle command left block busy");

    a_strobe_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("word without a command in flight");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_last |=> o_strobe)
        else $error("emit burst broke before last word");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !busy && !$past(o_strobe) |-> o_is_last)
        else $error("lone word not marked last");

endmodule

bind bounded_deque_with_value_delete bdq_chk u_bdq_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_operation(i_operation),
    .o_strobe   (o_strobe),
    .o_is_last  (o_is_last)
);

>>> tb/testbench.sv
// Self-checking testbench for the bounded deque with delete by value.
`timescale 1ns / 1ps

module testbench;

    localparam int CAP          = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 98;
    localparam int FILL_ITEMS   = 70;
    localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [bdq_pkg::OP_W-1:0]          op;
        logic signed [bdq_pkg::WORD_W-1:0] value;
        logic [bdq_pkg::KCNT_W-1:0]        count;
        int unsigned                       idle_pct;
        bit                                drain;
    } t_cmd;

    typedef struct {
        logic signed [bdq_pkg::WORD_W-1:0] element;
        logic                              is_last;
    } t_word;

    logic                              i_clk;
    logic                              i_rst_n     = 1'b0;
    logic                              start       = 1'b0;
    logic [bdq_pkg::OP_W-1:0]          i_operation = '0;
    logic signed [bdq_pkg::WORD_W-1:0] i_value     = '0;
    logic [bdq_pkg::KCNT_W-1:0]        i_count     = '0;
    logic                              busy;
    logic                              o_strobe;
    logic signed [bdq_pkg::WORD_W-1:0] o_element;
    logic                              o_is_last;

    t_cmd  cmd_fifo[$];
    t_word emit_due[$];
    t_cmd  cur_cmd;
    t_cmd  next_cmd;
    bit    have_next = 1'b0;

    int unsigned words_owed = 0;
    int unsigned words_seen = 0;
    int unsigned errors     = 0;
    int unsigned cycles     = 0;

    // shadow deque
    logic signed [bdq_pkg::WORD_W-1:0] dq_mem[CAP];
    logic [5:0]                        dq_head = '0;
    logic [6:0]                        dq_fill = '0;

    bounded_deque_with_value_delete #(.CAPACITY(CAP)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_count     (i_count),
        .o_strobe    (o_strobe),
        .o_element   (o_element),
        .o_is_last   (o_is_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [5:0] dq_pos(int i);
        return 6'((int'(dq_head) + i) % CAP);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic queue_emits(int first, int n, inout int unsigned k);
        t_word w;
        for (int i = 0; i < n; i++) begin
            w.element = dq_mem[dq_pos(first + i)];
            w.is_last = (i + 1 == n);
            emit_due.push_back(w);
            k++;
        end
    endtask

    // advance the shadow deque by one command and queue the words it emits
    task automatic deque_apply(input t_cmd c, output int unsigned k);
        int n;
        int j;
        k = 0;
        n = (int'(c.count) < int'(dq_fill)) ? int'(c.count) : int'(dq_fill);
        case (c.op)
            bdq_pkg::OP_PUSH_FRONT: if (dq_fill < CAP) begin
                dq_head = dq_head - 6'd1;
                dq_mem[dq_head] = c.value;
                dq_fill++;
            end
            bdq_pkg::OP_PUSH_BACK: if (dq_fill < CAP) begin
                dq_mem[dq_pos(int'(dq_fill))] = c.value;
                dq_fill++;
            end
            bdq_pkg::OP_POP_FRONT: if (dq_fill > 0) begin
                dq_head = dq_head + 6'd1;
                dq_fill--;
            end
            bdq_pkg::OP_POP_BACK: if (dq_fill > 0) dq_fill--;
            bdq_pkg::OP_CLEAR: begin
                dq_fill = '0;
                dq_head = '0;
            end
            bdq_pkg::OP_REMOVE: begin
                for (int i = 0; i < int'(dq_fill); i++) begin
                    if (dq_mem[dq_pos(i)] == c.value) begin
                        for (j = i; j + 1 < int'(dq_fill); j++)
                            dq_mem[dq_pos(j)] = dq_mem[dq_pos(j + 1)];
                        dq_fill--;
                        break;
                    end
                end
            end
            bdq_pkg::OP_EMIT_ALL:   queue_emits(0, int'(dq_fill), k);
            bdq_pkg::OP_EMIT_FIRST: queue_emits(0, n, k);
            bdq_pkg::OP_EMIT_LAST:  queue_emits(int'(dq_fill) - n, n, k);
            default: ;
        endcase
    endtask

    task automatic add_cmd(logic [bdq_pkg::OP_W-1:0] op,
                           logic signed [bdq_pkg::WORD_W-1:0] value,
                           logic [bdq_pkg::KCNT_W-1:0] count, int unsigned idle_pct,
                           bit drain);
        t_cmd c;
        c.op       = op;
        c.value    = value;
        c.count    = count;
        c.idle_pct = idle_pct;
        c.drain    = drain;
        cmd_fifo.push_back(c);
    endtask

    function automatic logic signed [bdq_pkg::WORD_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $signed($urandom_range(0, 6)) - 3;
        if (r < 55) return 32'sh7fffffff;
        if (r < 60) return 32'sh80000000;
        return $signed($urandom);
    endfunction

    function automatic logic [bdq_pkg::KCNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 7'd0;
        if (r == 1) return 7'd64;
        return 7'($urandom_range(0, 64));
    endfunction

    function automatic logic [bdq_pkg::OP_W-1:0] pick_op(bit filling);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 42) return bdq_pkg::OP_PUSH_BACK;
            if (r < 84) return bdq_pkg::OP_PUSH_FRONT;
            if (r < 86) return bdq_pkg::OP_POP_FRONT;
            if (r < 88) return bdq_pkg::OP_POP_BACK;
            if (r < 92) return bdq_pkg::OP_REMOVE;
        end else begin
            if (r < 10) return bdq_pkg::OP_PUSH_BACK;
            if (r < 20) return bdq_pkg::OP_PUSH_FRONT;
            if (r < 40) return bdq_pkg::OP_POP_FRONT;
            if (r < 60) return bdq_pkg::OP_POP_BACK;
            if (r < 75) return bdq_pkg::OP_REMOVE;
        end
        r = $urandom_range(0, 99);
        if (r < 30) return bdq_pkg::OP_EMIT_ALL;
        if (r < 60) return bdq_pkg::OP_EMIT_FIRST;
        if (r < 90) return bdq_pkg::OP_EMIT_LAST;
        if (r < 96) return bdq_pkg::OP_CLEAR;
        return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // driver
    always @(posedge i_clk) begin : drive
        int unsigned k;
        bit          slot_free;
        k = 0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            slot_free = !start || !busy;
            if (start && !busy) deque_apply(cur_cmd, k);
            if (k != 0) words_owed <= words_owed + k;
            if (slot_free) begin
                if (!have_next && cmd_fifo.size() > 0) begin
                    next_cmd  = cmd_fifo.pop_front();
                    have_next = 1'b1;
                end
                if (have_next && $urandom_range(0, 99) >= next_cmd.idle_pct &&
                    (!next_cmd.drain || words_owed + k == words_seen)) begin
                    cur_cmd     = next_cmd;
                    have_next   = 1'b0;
                    start       <= 1'b1;
                    i_operation <= next_cmd.op;
                    i_value     <= next_cmd.value;
                    i_count     <= next_cmd.count;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch
        t_word w;
        if (i_rst_n && o_strobe) begin
            if (emit_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d", o_element));
            end else begin
                w = emit_due.pop_front();
                if (o_element !== w.element)
                    report_mismatch($sformatf("element %0d, expected %0d",
                                              o_element, w.element));
                if (o_is_last !== w.is_last)
                    report_mismatch($sformatf("is_last %b, expected %b",
                                              o_is_last, w.is_last));
            end
            words_seen <= words_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int unsigned idle_plan[4];
        int unsigned pct;
        logic [bdq_pkg::OP_W-1:0] op;

        // directed: empty store, extremes, removal corners, unused code
        add_cmd(bdq_pkg::OP_EMIT_ALL,   0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_POP_FRONT,  0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_POP_BACK,   0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_REMOVE,     0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_FIRST, 0, 7'd64, 0, 1'b0);
        add_cmd(bdq_pkg::OP_PUSH_BACK,  32'sh7fffffff, 7'h7f, 0, 1'b0);
        add_cmd(bdq_pkg::OP_PUSH_FRONT, 32'sh80000000, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_PUSH_BACK,  -1, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_PUSH_BACK,  0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_ALL,   0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_FIRST, 0, 7'd64, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_LAST,  0, 7'd1, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_LAST,  0, 7'd0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_FIRST, 0, 7'd2, 0, 1'b0);
        add_cmd(bdq_pkg::OP_REMOVE,     12345, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_REMOVE,     -1, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_REMOVE,     0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_ALL,   0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_POP_BACK,   0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_POP_FRONT,  0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_PUSH_BACK,  5, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_ALL,   0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_CLEAR,      0, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_ALL,   0, 0, 0, 1'b0);
        add_cmd(OP_UNUSED_HI,           7, 7'd64, 0, 1'b0);
        add_cmd(bdq_pkg::OP_PUSH_FRONT, 7, 0, 0, 1'b0);
        add_cmd(bdq_pkg::OP_EMIT_LAST,  0, 7'd64, 0, 1'b0);

        // random: fill-heavy then drain-heavy in each idling phase
        idle_plan = '{0, 67, 14, 0};
        foreach (idle_plan[p]) begin
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pct = (p == 3 && i >= FILL_ITEMS) ? 0 : idle_plan[p];
                op  = pick_op(i < FILL_ITEMS);
                add_cmd(op, pick_value(), pick_count(), pct, i == 0);
            end
            add_cmd(bdq_pkg::OP_EMIT_ALL, 0, 0, idle_plan[p], 1'b0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (cmd_fifo.size() > 0 || have_next || start) @(negedge i_clk);
        while (words_seen != words_owed || busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (emit_due.size() != 0)
            report_mismatch($sformatf("%0d words never came", emit_due.size()));
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
